// ----- hw/rtl/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console character writer package
// Screen geometry, field widths, codes and the control and status bundles
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   localparam int OPERATION_W  = 2;
   localparam int CHAR_W       = 8;
   localparam int CELL_INDEX_W = 11;
   localparam int CURSOR_W     = 11;
   localparam int CELL_W       = 16;
   localparam int COLOR_W      = 4;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 4;

   localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0]  CHAR_RETURN  = 8'h0D;
   localparam logic [COLOR_W-1:0] FG_RESET     = 4'hF;
   localparam logic [COLOR_W-1:0] BG_RESET     = 4'h6;

   typedef enum logic [OPERATION_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FG_COLOR = 1'b0,
      CSR_BG_COLOR = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_WRITE,
      KIND_NEWLINE,
      KIND_RETURN,
      KIND_CLEAR,
      KIND_READ,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      logic accept;
      logic sweep_run;
      logic sweep_copy;
      logic rsp_load;
      logic rsp_from_read;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     last_row;
      logic     sweep_last;
   } status_type;

endpackage

// ----- hw/rtl/tccw_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one console operation per transaction.
// ----------------------------------------------------------------------------
interface tccw_req_if;
   logic                                valid;
   logic                                ready;
   logic [tccw_pkg::OPERATION_W-1:0]    operation;
   logic [tccw_pkg::CHAR_W-1:0]         char_code;
   logic [tccw_pkg::CELL_INDEX_W-1:0]   cell_index;

   modport source (output valid, output operation, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input operation, input char_code, input cell_index,
                   output ready);
endinterface

// ----- hw/rtl/tccw_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel that carries the cursor and cell value per transaction.
// ----------------------------------------------------------------------------
interface tccw_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tccw_pkg::CURSOR_W-1:0]   cursor_pos;
   logic [tccw_pkg::CELL_W-1:0]     cell_value;

   modport source (output valid, output cursor_pos, output cell_value, input ready);
   modport sink   (input valid, input cursor_pos, input cell_value, output ready);
endinterface

// ----- hw/rtl/tccw_datapath.sv -----
// ----------------------------------------------------------------------------
// Text console datapath
// Screen memory, cursor, color registers, sweep counter for scroll and clear,
// and the response payload register.
// ----------------------------------------------------------------------------
module tccw_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tccw_pkg::cmd_type                    cmd,
   output tccw_pkg::status_type                 status,
   input  logic [tccw_pkg::OPERATION_W-1:0]     req_operation,
   input  logic [tccw_pkg::CHAR_W-1:0]          req_char_code,
   input  logic [tccw_pkg::CELL_INDEX_W-1:0]    req_cell_index,
   input  logic                                 csr_we,
   input  logic [tccw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tccw_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic [tccw_pkg::CURSOR_W-1:0]        rsp_cursor_pos,
   output logic [tccw_pkg::CELL_W-1:0]          rsp_cell_value
);

   localparam int ADDR_W = tccw_pkg::ADDR_W;
   localparam int COL_W  = tccw_pkg::COL_W;
   localparam int ROW_W  = tccw_pkg::ROW_W;
   localparam int CELL_W = tccw_pkg::CELL_W;

   logic [CELL_W-1:0]  screen_mem_ff [tccw_pkg::CELL_COUNT];
   logic [CELL_W-1:0]  rdata_ff;
   logic               rd_oob_ff;

   logic [tccw_pkg::COLOR_W-1:0] fg_ff, fg_in;
   logic [tccw_pkg::COLOR_W-1:0] bg_ff, bg_in;

   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;

   logic [ADDR_W-1:0]  sweep_cnt_ff, sweep_cnt_in;
   logic               wr_valid_ff, wr_valid_in;
   logic               wr_copy_ff, wr_copy_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;

   logic [tccw_pkg::CURSOR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [CELL_W-1:0]             rsp_value_ff, rsp_value_in;

   tccw_pkg::kind_type kind;
   logic               last_row;
   logic               last_col;
   logic               char_we;
   logic [ADDR_W-1:0]  sweep_src;
   logic [ADDR_W-1:0]  raddr;
   logic [ADDR_W-1:0]  waddr;
   logic [CELL_W-1:0]  wdata;
   logic               mem_we;

   always_comb begin
      case (tccw_pkg::op_type'(req_operation))
         tccw_pkg::OP_PUT: begin
            if (req_char_code == tccw_pkg::CHAR_NEWLINE) begin
               kind = tccw_pkg::KIND_NEWLINE;
            end else if (req_char_code == tccw_pkg::CHAR_RETURN) begin
               kind = tccw_pkg::KIND_RETURN;
            end else begin
               kind = tccw_pkg::KIND_WRITE;
            end
         end
         tccw_pkg::OP_CLEAR: kind = tccw_pkg::KIND_CLEAR;
         tccw_pkg::OP_READ:  kind = tccw_pkg::KIND_READ;
         default:            kind = tccw_pkg::KIND_NOP;
      endcase
   end

   assign last_row = (row_ff == ROW_W'(tccw_pkg::ROWS - 1));
   assign last_col = (col_ff == COL_W'(tccw_pkg::COLUMNS - 1));

   assign status.kind       = kind;
   assign status.last_row   = last_row;
   assign status.sweep_last = (sweep_cnt_ff == ADDR_W'(tccw_pkg::CELL_COUNT - 1));

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_we) begin
         case (tccw_pkg::csr_index_type'(csr_index))
            tccw_pkg::CSR_FG_COLOR: fg_in = csr_wdata;
            tccw_pkg::CSR_BG_COLOR: bg_in = csr_wdata;
            default: begin
               fg_in = fg_ff;
               bg_in = bg_ff;
            end
         endcase
      end
   end

   always_comb begin
      pos_in = pos_ff;
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.accept) begin
         case (kind)
            tccw_pkg::KIND_WRITE: begin
               if (!last_col) begin
                  pos_in = pos_ff + ADDR_W'(1);
                  col_in = col_ff + COL_W'(1);
               end
            end
            tccw_pkg::KIND_NEWLINE: begin
               col_in = '0;
               if (last_row) begin
                  pos_in = pos_ff - ADDR_W'(col_ff);
               end else begin
                  pos_in = pos_ff - ADDR_W'(col_ff) + ADDR_W'(tccw_pkg::COLUMNS);
                  row_in = row_ff + ROW_W'(1);
               end
            end
            tccw_pkg::KIND_RETURN: begin
               pos_in = pos_ff - ADDR_W'(col_ff);
               col_in = '0;
            end
            tccw_pkg::KIND_CLEAR: begin
               pos_in = '0;
               row_in = '0;
               col_in = '0;
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   assign sweep_src    = sweep_cnt_ff + ADDR_W'(tccw_pkg::COLUMNS);
   assign sweep_cnt_in = cmd.sweep_run ? sweep_cnt_ff + ADDR_W'(1) : '0;
   assign wr_valid_in  = cmd.sweep_run;
   assign wr_addr_in   = sweep_cnt_ff;
   assign wr_copy_in   = cmd.sweep_copy &&
                         (int'(sweep_cnt_ff) < tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS);

   assign raddr   = cmd.sweep_run ? sweep_src : ADDR_W'(req_cell_index);
   assign char_we = cmd.accept && (kind == tccw_pkg::KIND_WRITE);
   assign mem_we  = wr_valid_ff || char_we;
   assign waddr   = wr_valid_ff ? wr_addr_ff : pos_ff;

   always_comb begin
      if (wr_valid_ff) begin
         wdata = wr_copy_ff ? rdata_ff : '0;
      end else begin
         wdata = {bg_ff, fg_ff, req_char_code};
      end
   end

   assign rsp_cursor_in = tccw_pkg::CURSOR_W'(pos_in);
   assign rsp_value_in  = (cmd.rsp_from_read && !rd_oob_ff) ? rdata_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff  <= screen_mem_ff[raddr];
      rd_oob_ff <= (int'(req_cell_index) >= tccw_pkg::CELL_COUNT);
      wr_addr_ff <= wr_addr_in;
      wr_copy_ff <= wr_copy_in;
      if (cmd.rsp_load) begin
         rsp_cursor_ff <= rsp_cursor_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= tccw_pkg::FG_RESET;
         bg_ff        <= tccw_pkg::BG_RESET;
         pos_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         sweep_cnt_ff <= '0;
         wr_valid_ff  <= 1'b0;
      end else begin
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         pos_ff       <= pos_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sweep_cnt_ff <= sweep_cnt_in;
         wr_valid_ff  <= wr_valid_in;
      end
   end

   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_cell_value = rsp_value_ff;

`ifndef ASSERT_OFF
   a_cursor_consistent: assert property (@(posedge clock) disable iff (reset)
      int'(pos_ff) == int'(row_ff) * tccw_pkg::COLUMNS + int'(col_ff))
      else $error("cursor position disagrees with row and column");

   a_no_write_collision: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> !char_we)
      else $error("character write collides with a sweep write");
`endif

endmodule

// ----- hw/rtl/tccw_ctrl.sv -----
// ----------------------------------------------------------------------------
// Text console controller
// Sequences request acceptance, screen sweeps, read waits and the response
// valid flag.
// ----------------------------------------------------------------------------
module tccw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tccw_pkg::status_type   status,
   output tccw_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_SCROLL,
      ST_DRAIN,
      ST_READ,
      ST_IDLE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      reply_ff, reply_in;
   logic      ready;
   logic      accept;
   logic      load_now;

   assign ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = ready && req_valid;

   always_comb begin
      load_now = 1'b0;
      if (accept) begin
         case (status.kind)
            tccw_pkg::KIND_CLEAR, tccw_pkg::KIND_READ: load_now = 1'b0;
            tccw_pkg::KIND_NEWLINE: load_now = !status.last_row;
            default: load_now = 1'b1;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      reply_in     = reply_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.accept   = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (load_now) begin
                  cmd.rsp_load = 1'b1;
                  rsp_valid_in = 1'b1;
               end else if (status.kind == tccw_pkg::KIND_CLEAR) begin
                  state_in = ST_CLEAR;
                  reply_in = 1'b1;
               end else if (status.kind == tccw_pkg::KIND_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_SCROLL;
                  reply_in = 1'b1;
               end
            end
         end
         ST_CLEAR, ST_SCROLL: begin
            cmd.sweep_run  = 1'b1;
            cmd.sweep_copy = (state_ff == ST_SCROLL);
            if (status.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (reply_ff) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
            reply_in = 1'b0;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            cmd.rsp_load      = 1'b1;
            cmd.rsp_from_read = 1'b1;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         reply_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         reply_ff     <= reply_in;
      end
   end

   assign req_ready = ready;
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_sweep_ends_in_drain: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLEAR || state_ff == ST_SCROLL) && status.sweep_last)
      |=> (state_ff == ST_DRAIN))
      else $error("sweep did not finish with a drain cycle");

   a_read_answers_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid_ff)
      else $error("read result was not presented");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten before it was taken");
`endif

endmodule

// ----- hw/rtl/text_console_char_writer_top.sv -----
// ----------------------------------------------------------------------------
// Text console character writer
// Screen buffer of attribute and character cells with a cursor, driven by
// put, clear and read transactions.
//
//   Channel   Direction  Handshake      Payload
//   req_port  in         valid/ready    operation, char_code, cell_index
//   rsp_port  out        valid/ready    cursor_pos, cell_value
//   csr_*     in         write enable   csr_index, csr_wdata (fg, bg color)
//
// Put, carriage return, non-scrolling newline and unused codes load the
// response when taken. A read goes through the registered read port of the
// screen memory and the read state. Clear and a scrolling newline run a sweep
// that moves one cell per cycle through the single write port of the screen
// memory, then a drain state. After reset a clearing pass runs before the
// first request transaction is taken; CSR writes are taken throughout.
// A pending response is held while rsp_port.ready is low; a new request is
// taken in the cycle the response register empties or drains.
// ----------------------------------------------------------------------------
module text_console_char_writer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   tccw_req_if.sink                             req_port,
   tccw_rsp_if.source                           rsp_port,
   input  logic                                 csr_we,
   input  logic [tccw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tccw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   tccw_pkg::cmd_type    cmd;
   tccw_pkg::status_type status;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_port.operation),
      .req_char_code  (req_port.char_code),
      .req_cell_index (req_port.cell_index),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_cursor_pos (rsp_port.cursor_pos),
      .rsp_cell_value (rsp_port.cell_value)
   );

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Drives put, clear, read and unused-code transactions into the console
// writer and keeps its own copy of the screen, cursor and colors. Each
// transaction it sends adds the expected cursor and cell value to a queue,
// and each response is compared with the oldest entry. The colors change
// between phases only while nothing is in flight. The sender and the
// receiver both idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import tccw_pkg::*;

   localparam logic [OPERATION_W-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 20000;
   localparam int PHASE_ITEMS = 100;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_pos;
      logic [CELL_W-1:0]   cell_value;
   } reply_type;

   class console_scoreboard;
      logic [CELL_W-1:0]  screen [CELL_COUNT];
      int unsigned        cursor;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      reply_type          expected_q [$];
      int                 errors;
      int                 checked;

      function new();
         foreach (screen[i]) screen[i] = '0;
         cursor  = 0;
         fg      = FG_RESET;
         bg      = BG_RESET;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_color(csr_index_type which, logic [COLOR_W-1:0] value);
         if (which == CSR_FG_COLOR) fg = value;
         else bg = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [OPERATION_W-1:0] op, logic [CHAR_W-1:0] ch,
                                 logic [CELL_INDEX_W-1:0] idx);
         int unsigned row_start;
         int unsigned next_pos;
         reply_type   want;
         want.cell_value = '0;
         case (op)
            OP_PUT: begin
               row_start = (cursor / COLUMNS) * COLUMNS;
               if (ch == CHAR_NEWLINE) begin
                  next_pos = row_start + COLUMNS;
                  if (next_pos >= CELL_COUNT) begin
                     for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                     for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = '0;
                     next_pos -= COLUMNS;
                  end
                  cursor = next_pos;
               end else if (ch == CHAR_RETURN) begin
                  cursor = row_start;
               end else begin
                  screen[cursor] = {bg, fg, ch};
                  if ((cursor % COLUMNS) < COLUMNS - 1) cursor++;
               end
            end
            OP_CLEAR: begin
               foreach (screen[i]) screen[i] = '0;
               cursor = 0;
            end
            OP_READ: begin
               if (idx < CELL_COUNT) want.cell_value = screen[idx];
            end
            default: begin
            end
         endcase
         want.cursor_pos = CURSOR_W'(cursor);
         expected_q.push_back(want);
      endfunction

      function void check_response(logic [CURSOR_W-1:0] cursor_pos,
                                   logic [CELL_W-1:0] cell_value);
         reply_type want;
         checked++;
         if (expected_q.size() == 0) begin
            $error("unexpected response: cursor_pos %0d cell_value 0x%04h",
                   cursor_pos, cell_value);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, cursor_pos);
            errors++;
         end
         if (cell_value !== want.cell_value) begin
            $error("cell_value: expected 0x%04h, actual 0x%04h", want.cell_value, cell_value);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tccw_req_if req_chan ();
   tccw_rsp_if rsp_chan ();

   console_scoreboard sb;
   int burst_left = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   bit long_hold_done = 1'b0;

   text_console_char_writer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_chan),
      .rsp_port  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic offer(input logic [OPERATION_W-1:0] op, input logic [CHAR_W-1:0] ch,
                        input logic [CELL_INDEX_W-1:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= op;
      req_chan.char_code  <= ch;
      req_chan.cell_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(op, ch, idx);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      csr_we    <= 1'b1;
      csr_index <= CSR_FG_COLOR;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= CSR_BG_COLOR;
      csr_wdata <= bg;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_color(CSR_FG_COLOR, fg);
      sb.set_color(CSR_BG_COLOR, bg);
   endtask

   function automatic logic [CHAR_W-1:0] glyph();
      logic [CHAR_W-1:0] c;
      c = CHAR_W'($urandom_range(0, 255));
      if (c == CHAR_NEWLINE || c == CHAR_RETURN) c = 8'h20;
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] any_char();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CELL_INDEX_W-1:0] any_index();
      return CELL_INDEX_W'($urandom_range(0, 2047));
   endfunction

   task automatic run_phase(input int target);
      int start;
      int kind;
      int len;
      int r;
      logic [CELL_INDEX_W-1:0] idx;
      logic [OPERATION_W-1:0]  op;
      start = items_sent;
      repeat ($urandom_range(78, 90)) offer(OP_PUT, glyph(), any_index());
      while (items_sent - start < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 8);
            repeat (len) offer(OP_PUT, glyph(), any_index());
            offer(OP_PUT, ($urandom_range(0, 4) == 0) ? CHAR_RETURN : CHAR_NEWLINE,
                  any_index());
         end else if (kind < 70) begin
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 3))
                  0: idx = any_index();
                  1: idx = CELL_INDEX_W'(sb.cursor - sb.cursor % COLUMNS +
                                         $urandom_range(0, COLUMNS - 1));
                  2: idx = CELL_INDEX_W'($urandom_range(CELL_COUNT - 2 * COLUMNS,
                                                        CELL_COUNT - 1));
                  default: idx = CELL_INDEX_W'($urandom_range(0, 2 * COLUMNS - 1));
               endcase
               offer(OP_READ, any_char(), idx);
            end
         end else if (kind < 78) begin
            repeat ($urandom_range(1, 30)) offer(OP_PUT, CHAR_NEWLINE, any_index());
         end else if (kind < 79) begin
            offer(OP_CLEAR, any_char(), any_index());
         end else if (kind < 85) begin
            offer(OP_UNUSED, any_char(), any_index());
         end else if (kind < 95) begin
            repeat ($urandom_range(1, 10)) begin
               r = $urandom_range(0, 49);
               if (r < 30) op = OP_PUT;
               else if (r < 45) op = OP_READ;
               else if (r < 49) op = OP_UNUSED;
               else op = OP_CLEAR;
               offer(op, any_char(), any_index());
            end
         end else begin
            offer(OP_PUT, any_char(), any_index());
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_response(rsp_chan.cursor_pos, rsp_chan.cell_value);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("text_console_char_writer_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int mode;
      rsp_chan.ready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            if (!long_hold_done && sb.checked >= 150 && req_chan.valid) begin
               long_hold_done = 1'b1;
               rsp_chan.ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end else begin
               case (mode)
                  0: rsp_chan.ready <= 1'b1;
                  1: rsp_chan.ready <= 1'($urandom_range(0, 1));
                  default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   initial begin
      sb = new();
      req_chan.valid      <= 1'b0;
      req_chan.operation  <= OP_PUT;
      req_chan.char_code  <= '0;
      req_chan.cell_index <= '0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_FG_COLOR;
      csr_wdata           <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Short directed run at the reset colors.
      offer(OP_READ,  8'h00, 11'd0);
      offer(OP_PUT,   8'h41, 11'd0);
      offer(OP_PUT,   8'hFF, 11'd2047);
      offer(OP_PUT,   8'h80, 11'd1024);
      offer(OP_PUT,   8'h00, 11'd0);
      offer(OP_READ,  8'hFF, 11'd0);
      offer(OP_READ,  8'h00, 11'd3);
      offer(OP_PUT,   CHAR_RETURN, 11'd0);
      offer(OP_PUT,   8'h7E, 11'd0);
      offer(OP_PUT,   CHAR_NEWLINE, 11'd2047);
      offer(OP_PUT,   8'h5A, 11'd0);
      offer(OP_READ,  8'h00, 11'd80);
      offer(OP_READ,  CHAR_NEWLINE, 11'd0);
      offer(OP_READ,  8'h00, 11'd1999);
      offer(OP_READ,  8'h00, 11'd2000);
      offer(OP_READ,  8'hFF, 11'd2047);
      offer(OP_UNUSED, 8'hFF, 11'd2047);
      offer(OP_UNUSED, 8'h00, 11'd0);
      offer(OP_CLEAR, 8'h41, 11'd5);
      offer(OP_READ,  8'h00, 11'd0);
      offer(OP_READ,  8'h00, 11'd80);

      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: write_colors(4'h0, 4'h0);
            1: write_colors(4'hF, 4'hF);
            2: write_colors(4'h0, 4'hF);
            3: write_colors(4'hF, 4'h0);
            default: write_colors(COLOR_W'($urandom_range(0, 15)),
                                  COLOR_W'($urandom_range(0, 15)));
         endcase
         run_phase(PHASE_ITEMS);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("text_console_char_writer_top: match");
      end else begin
         $display("text_console_char_writer_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_req_if.sv
hw/rtl/tccw_rsp_if.sv
hw/rtl/tccw_datapath.sv
hw/rtl/tccw_ctrl.sv
hw/rtl/text_console_char_writer_top.sv
sim/tb_top.sv
